// File: hdl/dkp_pkg.sv
// ----------------------------------------------------------------------------
// dkp_pkg
// Shared types, sizes and base-code helpers for the two-bit k-mer packer.
// ----------------------------------------------------------------------------
package dkp_pkg;

	localparam int WORDS          = 4;
	localparam int WORD_W         = 64;
	localparam int BASES_PER_WORD = WORD_W / 2;
	localparam int CAPACITY       = WORDS * BASES_PER_WORD;
	localparam int FULL_W         = WORDS * WORD_W;
	localparam int CNT_W          = $clog2(CAPACITY + 1);
	localparam int REM_W          = $clog2(WORDS + 1);
	localparam int IDX_W          = 4;

	localparam logic [7:0] CHAR_UC_A = 8'h41;
	localparam logic [7:0] CHAR_UC_C = 8'h43;
	localparam logic [7:0] CHAR_UC_G = 8'h47;
	localparam logic [7:0] CHAR_UC_T = 8'h54;
	localparam logic [7:0] CHAR_LC_A = 8'h61;
	localparam logic [7:0] CHAR_LC_C = 8'h63;
	localparam logic [7:0] CHAR_LC_G = 8'h67;
	localparam logic [7:0] CHAR_LC_T = 8'h74;

	typedef logic [1:0] code_t;

	localparam code_t CODE_0 = 2'd0;
	localparam code_t CODE_1 = 2'd1;
	localparam code_t CODE_2 = 2'd2;
	localparam code_t CODE_3 = 2'd3;

	typedef struct packed {
		logic [7:0] base_char;
		logic       first_base;
		logic       last_base;
		logic       reverse_strand;
	} base_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] word_value;
		logic [IDX_W-1:0]  word_index;
		logic              last_word;
		logic              overflow;
	} word_item_t;

	// Snapshot handed from the packer to the emitter on a last base
	typedef struct packed {
		logic              load;
		logic              overflow;
		logic [FULL_W-1:0] words;
	} snap_t;

	function automatic code_t fwd_code(input logic [7:0] ch);
		code_t c;
		case (ch)
			CHAR_UC_C, CHAR_LC_C: c = CODE_1;
			CHAR_UC_G, CHAR_LC_G: c = CODE_2;
			CHAR_UC_T, CHAR_LC_T: c = CODE_3;
			default:              c = CODE_0;
		endcase
		return c;
	endfunction

	function automatic code_t rev_code(input logic [7:0] ch);
		code_t c;
		case (ch)
			CHAR_UC_A, CHAR_LC_A: c = CODE_3;
			CHAR_UC_C, CHAR_LC_C: c = CODE_2;
			CHAR_UC_G, CHAR_LC_G: c = CODE_1;
			default:              c = CODE_0;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/dna_kmer_two_bit_packer_top.sv
// ----------------------------------------------------------------------------
// dna_kmer_two_bit_packer_top
// Two-bit DNA packer with forward and reverse-complement modes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  base     | base_valid / base_ready | base_data  (char, first, last, strand)
//  word     | word_valid / word_ready | word_data  (value, index, last, ovf)
//
//  One base request is taken every cycle unless a last base is held in the input
//  register behind a busy emitter; a base passes the input register, then updates
//  the packed register. A last base snapshots the register; the emitter then sends
//  WORDS words, one per cycle while the receiver is ready, each going from the
//  snapshot register through the output register. A further last base waits in
//  the input register while a snapshot is still being sent, so runs of WORDS
//  bases or fewer are limited by the emitter.
//  Reset clears the packed register, count, strand and overflow flag, and
//  empties both the input stage and the output register.
// ----------------------------------------------------------------------------
module dna_kmer_two_bit_packer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                base_valid,
	output logic                base_ready,
	input  dkp_pkg::base_item_t base_data,
	output logic                word_valid,
	input  logic                word_ready,
	output dkp_pkg::word_item_t word_data
);

	// input stage
	logic                valid_s1;
	dkp_pkg::base_item_t item_s1;

	// control between stages
	logic           emit_busy;
	logic           step;
	dkp_pkg::snap_t snap;

	// A base moves on unless it is a last base and the emitter is still sending
	assign step       = valid_s1 & (~item_s1.last_base | ~emit_busy);
	assign base_ready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (base_valid && base_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (base_valid && base_ready) begin
			item_s1 <= base_data;
		end
	end

	dkp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.snap   (snap)
	);

	dkp_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap),
		.busy       (emit_busy),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_data  (word_data)
	);

	// a snapshot is only taken when the emitter is free
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		snap.load |-> !emit_busy)
		else $error("snapshot loaded while emitter busy");

	// the input stage only stalls on a last base behind a busy emitter
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!base_ready |-> (valid_s1 && item_s1.last_base && emit_busy))
		else $error("input stalled without cause");

	// the last-word mark sits on the top word only
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_data.last_word) |->
		(word_data.word_index == dkp_pkg::IDX_W'(dkp_pkg::WORDS - 1)))
		else $error("last word mark on wrong index");

endmodule

// File: hdl/dkp_packer.sv
// ----------------------------------------------------------------------------
// dkp_packer
// Packed register, base count, strand mode and overflow flag; one base a step.
// ----------------------------------------------------------------------------
module dkp_packer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  dkp_pkg::base_item_t item,
	output dkp_pkg::snap_t     snap
);

	logic [dkp_pkg::FULL_W-1:0] reg_q, cur_reg, nxt_reg;
	logic [dkp_pkg::CNT_W-1:0]  cnt_q, cur_cnt, nxt_cnt;
	logic                       mode_q, cur_mode;
	logic                       ovf_q, cur_ovf, nxt_ovf;
	dkp_pkg::code_t             fcode, rcode;

	always_comb begin
		// first base clears the run before it is packed
		cur_reg  = item.first_base ? '0 : reg_q;
		cur_cnt  = item.first_base ? '0 : cnt_q;
		cur_ovf  = item.first_base ? 1'b0 : ovf_q;
		cur_mode = item.first_base ? item.reverse_strand : mode_q;
		fcode    = dkp_pkg::fwd_code(item.base_char);
		rcode    = dkp_pkg::rev_code(item.base_char);
		nxt_reg  = cur_reg;
		nxt_cnt  = cur_cnt;
		nxt_ovf  = cur_ovf;
		if (cur_cnt >= dkp_pkg::CNT_W'(dkp_pkg::CAPACITY)) begin
			nxt_ovf = 1'b1;
		end else if (cur_mode) begin
			// reverse complement: base i lands in slot i
			for (int b = 0; b < dkp_pkg::CAPACITY; b++) begin
				if (cur_cnt == dkp_pkg::CNT_W'(b)) begin
					nxt_reg[2*b +: 2] = cur_reg[2*b +: 2] | rcode;
				end
			end
			nxt_cnt = cur_cnt + 1'b1;
		end else begin
			nxt_reg = {cur_reg[dkp_pkg::FULL_W-3:0], fcode};
			nxt_cnt = cur_cnt + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q  <= '0;
			cnt_q  <= '0;
			mode_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (step) begin
			reg_q  <= nxt_reg;
			cnt_q  <= nxt_cnt;
			mode_q <= cur_mode;
			ovf_q  <= nxt_ovf;
		end
	end

	assign snap.load     = step & item.last_base;
	assign snap.overflow = nxt_ovf;
	assign snap.words    = nxt_reg;

endmodule

// File: hdl/dkp_emitter.sv
// ----------------------------------------------------------------------------
// dkp_emitter
// Holds a snapshot of the packed register and sends it out word 0 first.
// ----------------------------------------------------------------------------
module dkp_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  dkp_pkg::snap_t      snap,
	output logic                busy,
	output logic                word_valid,
	input  logic                word_ready,
	output dkp_pkg::word_item_t word_data
);

	logic [dkp_pkg::FULL_W-1:0] snap_q;
	logic                       ovf_q;
	logic [dkp_pkg::REM_W-1:0]  rem_q;
	logic [dkp_pkg::IDX_W-1:0]  idx_q;
	logic                       out_valid_q;
	dkp_pkg::word_item_t        out_q;
	logic                       take;

	assign busy = (rem_q != '0);
	assign take = busy & (~out_valid_q | word_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (snap.load) begin
				rem_q <= dkp_pkg::REM_W'(dkp_pkg::WORDS);
			end else if (take) begin
				rem_q <= rem_q - 1'b1;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (word_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap.load) begin
			snap_q <= snap.words;
			ovf_q  <= snap.overflow;
			idx_q  <= '0;
		end else if (take) begin
			snap_q <= snap_q >> dkp_pkg::WORD_W;
			idx_q  <= idx_q + 1'b1;
		end
		if (take) begin
			out_q.word_value <= snap_q[dkp_pkg::WORD_W-1:0];
			out_q.word_index <= idx_q;
			out_q.last_word  <= (idx_q == dkp_pkg::IDX_W'(dkp_pkg::WORDS - 1));
			out_q.overflow   <= ovf_q;
		end
	end

	assign word_valid = out_valid_q;
	assign word_data  = out_q;

endmodule

// File: tb/tb_dna_kmer_two_bit_packer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dna_kmer_two_bit_packer_top
// Self-checking bench for the two-bit DNA packer. Bases are fed as valid/ready
// requests; every accepted base updates a local model of the packed register,
// and each last base queues the WORDS words expected back on the word channel.
// ----------------------------------------------------------------------------
module tb_dna_kmer_two_bit_packer_top;

	import dkp_pkg::*;

	// Sizing of the run
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 20;

	// Idle percentages per phase: sender-heavy, receiver-heavy, then flat out
	localparam int SEND_IDLE [3] = '{34, 55, 0};
	localparam int RECV_IDLE [3] = '{55, 34, 0};
	localparam int PHASE_ITEMS [3] = '{130, 160, 130};

	localparam logic [7:0] LETTERS [8] = '{CHAR_UC_A, CHAR_UC_C, CHAR_UC_G, CHAR_UC_T,
		CHAR_LC_A, CHAR_LC_C, CHAR_LC_G, CHAR_LC_T};

	// ------------------------------------------------------------------------
	// Scoreboard: local model of the packed register plus the queue of words
	// still owed by the block.
	// ------------------------------------------------------------------------
	class packed_word_checker;
		logic [FULL_W-1:0] pack_bits;
		int unsigned       bases_held;
		bit                reverse_mode;
		bit                dropped_any;
		word_item_t        expected_words[$];
		int                errors;
		int                words_checked;
		int                runs_closed;
		int                overflow_words;

		function new();
			pack_bits      = '0;
			bases_held     = 0;
			reverse_mode   = 1'b0;
			dropped_any    = 1'b0;
			errors         = 0;
			words_checked  = 0;
			runs_closed    = 0;
			overflow_words = 0;
		endfunction

		// Case is folded by setting bit 5; only the two cases of a letter fold
		// onto the lower-case code. Reverse complement of ACGT is the bitwise
		// inverse of the forward code, and anything unknown is zero either way.
		function code_t base_code(input logic [7:0] ch, input bit rc);
			code_t c;
			case (ch | 8'h20)
				CHAR_LC_A: c = CODE_0;
				CHAR_LC_C: c = CODE_1;
				CHAR_LC_G: c = CODE_2;
				CHAR_LC_T: c = CODE_3;
				default:   return CODE_0;
			endcase
			return rc ? ~c : c;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void note_base(input base_item_t b);
			word_item_t w;
			if (b.first_base) begin
				pack_bits    = '0;
				bases_held   = 0;
				dropped_any  = 1'b0;
				reverse_mode = b.reverse_strand;
			end
			if (bases_held >= CAPACITY) begin
				dropped_any = 1'b1;
			end else if (reverse_mode) begin
				pack_bits[2*bases_held +: 2] |= base_code(b.base_char, 1'b1);
				bases_held++;
			end else begin
				pack_bits = {pack_bits[FULL_W-3:0], base_code(b.base_char, 1'b0)};
				bases_held++;
			end
			if (b.last_base) begin
				runs_closed++;
				for (int i = 0; i < WORDS; i++) begin
					w.word_value = pack_bits[i*WORD_W +: WORD_W];
					w.word_index = IDX_W'(i);
					w.last_word  = (i == WORDS - 1);
					w.overflow   = dropped_any;
					expected_words.push_back(w);
				end
			end
		endfunction

		function void report_field(input string name, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
			errors++;
			$display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want_v,
				got_v);
		endfunction

		function void check_word(input word_item_t got);
			word_item_t want;
			words_checked++;
			if (got.overflow)
				overflow_words++;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none actual %p", $time, got);
				return;
			end
			want = expected_words.pop_front();
			if (got.word_value !== want.word_value)
				report_field("word_value", want.word_value, got.word_value);
			if (got.word_index !== want.word_index)
				report_field("word_index", WORD_W'(want.word_index),
					WORD_W'(got.word_index));
			if (got.last_word !== want.last_word)
				report_field("last_word", WORD_W'(want.last_word), WORD_W'(got.last_word));
			if (got.overflow !== want.overflow)
				report_field("overflow", WORD_W'(want.overflow), WORD_W'(got.overflow));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block
	// ------------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       base_valid = 1'b0;
	logic       base_ready;
	base_item_t base_data = '0;
	logic       word_valid;
	logic       word_ready = 1'b0;
	word_item_t word_data;

	packed_word_checker sb = new();

	int send_idle_pct = 0;
	int word_idle_pct = 0;
	int requests_sent = 0;
	int cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dna_kmer_two_bit_packer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_valid (base_valid),
		.base_ready (base_ready),
		.base_data  (base_data),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_data  (word_data)
	);

	// ------------------------------------------------------------------------
	// Monitors: both channels sampled at the rising edge. A base request
	// reaches the scoreboard well before any word it causes can come out.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && base_valid && base_ready)
			sb.note_base(base_data);
		if (arst_n && word_valid && word_ready)
			sb.check_word(word_data);
	end

	// Receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		word_ready = ($urandom_range(99) >= word_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sender. Called at a falling edge; may idle first, then holds the
	// request until it is taken. Valid only drops when an idle gap is drawn,
	// so back-to-back requests keep it high.
	// ------------------------------------------------------------------------
	task automatic send_base(input base_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			base_valid = 1'b0;
			@(negedge clk);
		end
		base_valid = 1'b1;
		base_data  = item;
		do @(posedge clk); while (!base_ready);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic send_fields(input logic [7:0] ch, input bit f, input bit l, input bit r);
		base_item_t item;
		item.base_char      = ch;
		item.first_base     = f;
		item.last_base      = l;
		item.reverse_strand = r;
		send_base(item);
	endtask

	// Mostly real letters in either case, some arbitrary byte codes
	function automatic logic [7:0] pick_char();
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(255));
		return LETTERS[$urandom_range(7)];
	endfunction

	// A run of bases; now and then the first or last mark is left off, so
	// runs chain onto the stored state or merge into the next run.
	// reverse_strand on later bases is random since the block must ignore it.
	task automatic random_run(input int len);
		bit strand_sel;
		bit keep_first;
		bit keep_last;
		strand_sel = 1'($urandom_range(1));
		keep_first = ($urandom_range(9) != 0);
		keep_last  = ($urandom_range(9) != 0);
		for (int i = 0; i < len; i++)
			send_fields(pick_char(), (i == 0) && keep_first, (i == len - 1) && keep_last,
				(i == 0) ? strand_sel : 1'($urandom_range(1)));
	endtask

	// Requests with every field random
	task automatic noise_burst(input int n);
		for (int i = 0; i < n; i++)
			send_fields(8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int phase_start;
		int pick;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = SEND_IDLE[0];
		word_idle_pct = RECV_IDLE[0];

		// Directed: single-base run, then forward letters in mixed case
		send_fields(CHAR_UC_A, 1'b1, 1'b1, 1'b0);
		send_fields(CHAR_UC_C, 1'b1, 1'b0, 1'b0);
		send_fields(CHAR_LC_G, 1'b0, 1'b0, 1'b1);
		send_fields(CHAR_UC_T, 1'b0, 1'b0, 1'b0);
		send_fields(CHAR_LC_A, 1'b0, 1'b0, 1'b1);
		send_fields(CHAR_LC_T, 1'b0, 1'b1, 1'b0);
		// Reverse complement, byte extremes count as unknown letters
		send_fields(CHAR_LC_A, 1'b1, 1'b0, 1'b1);
		send_fields(CHAR_UC_C, 1'b0, 1'b0, 1'b0);
		send_fields(8'h00,     1'b0, 1'b0, 1'b0);
		send_fields(CHAR_UC_G, 1'b0, 1'b0, 1'b1);
		send_fields(CHAR_LC_T, 1'b0, 1'b0, 1'b0);
		send_fields(8'hFF,     1'b0, 1'b1, 1'b0);
		// Run carries on past its last base with no new first base
		send_fields(CHAR_LC_G, 1'b0, 1'b1, 1'b0);
		send_fields(CHAR_LC_C, 1'b0, 1'b0, 1'b1);
		send_fields(CHAR_UC_A, 1'b0, 1'b1, 1'b0);
		// Forward run with odd letters, then a one-base reverse run
		send_fields(8'h4E,     1'b1, 1'b0, 1'b0);
		send_fields(CHAR_UC_T, 1'b0, 1'b0, 1'b1);
		send_fields(8'h80,     1'b0, 1'b0, 1'b0);
		send_fields(CHAR_LC_C, 1'b0, 1'b1, 1'b1);
		send_fields(CHAR_LC_A, 1'b1, 1'b1, 1'b1);

		// Random phases; the middle one opens with a run at or past capacity
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = SEND_IDLE[p];
			word_idle_pct = RECV_IDLE[p];
			phase_start   = requests_sent;
			if (p == 1)
				random_run($urandom_range(CAPACITY, CAPACITY + 12));
			while (requests_sent - phase_start < PHASE_ITEMS[p]) begin
				pick = $urandom_range(19);
				if (pick < 2)
					noise_burst($urandom_range(1, 4));
				else
					random_run($urandom_range(1, 10));
			end
		end
		base_valid = 1'b0;

		// Let the emitter drain, then watch for stray words
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d base requests, %0d runs closed, %0d words checked",
			requests_sent, sb.runs_closed, sb.words_checked);
		$display("summary: %0d words flagged overflow, %0d errors",
			sb.overflow_words, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
